// ----- rtl/core/rpcs_pkg.sv -----
// Shared types, codes and tables for the rotated panel command serializer.
// No dependencies; imported by every module of the block.
package rpcs_pkg;

    localparam int PANEL_WIDTH_DEF  = 240;
    localparam int PANEL_HEIGHT_DEF = 320;
    localparam int QUEUE_DEPTH_DEF  = 2;

    localparam int JOB_WORDS = 8;
    localparam int IDX_W     = 5;
    localparam int REG_W     = 3;

    localparam logic [1:0] FUNC_PIXEL  = 2'd0;
    localparam logic [1:0] FUNC_WINDOW = 2'd1;
    localparam logic [1:0] FUNC_ROTATE = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    localparam logic [15:0] ADDR_ENTRY_MODE = 16'h0003;
    localparam logic [15:0] ADDR_CNT_X      = 16'h0020;
    localparam logic [15:0] ADDR_CNT_Y      = 16'h0021;
    localparam logic [15:0] ADDR_GRAM       = 16'h0022;
    localparam logic [15:0] ADDR_WIN_XS     = 16'h0050;
    localparam logic [15:0] ADDR_WIN_XE     = 16'h0051;
    localparam logic [15:0] ADDR_WIN_YS     = 16'h0052;
    localparam logic [15:0] ADDR_WIN_YE     = 16'h0053;

    localparam logic [15:0] MODE_ROT_0   = 16'h1030;
    localparam logic [15:0] MODE_ROT_90  = 16'h1028;
    localparam logic [15:0] MODE_ROT_180 = 16'h1000;
    localparam logic [15:0] MODE_ROT_270 = 16'h1018;

    typedef enum logic [1:0] {
        KIND_PIXEL,
        KIND_WINDOW,
        KIND_ROTATE
    } t_kind;

    typedef struct packed {
        logic [1:0]  func;
        logic [8:0]  x_first;
        logic [8:0]  y_first;
        logic [8:0]  x_second;
        logic [8:0]  y_second;
        logic [15:0] pixel_color;
    } t_in_item;

    typedef struct packed {
        logic [7:0] bus_byte;
        logic       is_data;
        logic       last;
    } t_out_item;

    typedef struct packed {
        t_kind                       kind;
        logic [JOB_WORDS-1:0][15:0]  words;
    } t_job;

    function automatic logic [15:0] mode_word(input logic [1:0] rot);
        logic [15:0] m;
        unique case (rot)
            ROT_90:  m = MODE_ROT_90;
            ROT_180: m = MODE_ROT_180;
            ROT_270: m = MODE_ROT_270;
            default: m = MODE_ROT_0;
        endcase
        return m;
    endfunction

    function automatic logic [15:0] win_addr(input logic [REG_W-1:0] r);
        logic [15:0] a;
        unique case (r)
            3'd0:    a = ADDR_WIN_XS;
            3'd1:    a = ADDR_WIN_XE;
            3'd2:    a = ADDR_WIN_YS;
            3'd3:    a = ADDR_WIN_YE;
            3'd4:    a = ADDR_CNT_X;
            default: a = ADDR_CNT_Y;
        endcase
        return a;
    endfunction

    function automatic logic [15:0] reg_addr(input t_kind k, input logic [REG_W-1:0] r);
        logic [15:0] a;
        unique case (k)
            KIND_PIXEL: begin
                unique case (r)
                    3'd0:    a = ADDR_CNT_X;
                    3'd1:    a = ADDR_CNT_Y;
                    default: a = ADDR_GRAM;
                endcase
            end
            KIND_ROTATE: begin
                a = (r == '0) ? ADDR_ENTRY_MODE : win_addr(r - 3'd1);
            end
            default: a = win_addr(r);
        endcase
        return a;
    endfunction

    function automatic logic [REG_W-1:0] last_reg(input t_kind k);
        logic [REG_W-1:0] r;
        unique case (k)
            KIND_PIXEL:  r = 3'd2;
            KIND_ROTATE: r = 3'd6;
            default:     r = 3'd5;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/rpcs_front.sv -----
// Front end: holds the rotation register, accepts items and maps them to jobs.
// Depends on rpcs_pkg.
module rpcs_front import rpcs_pkg::*; #(
    parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_valid,
    input  logic [1:0] i_cfg_data,
    input  logic     i_in_valid,
    input  t_in_item i_in,
    input  logic     i_q_full,
    output logic     o_in_ready,
    output logic     o_push,
    output t_job     o_job
);

    localparam logic [15:0] WM1 = 16'(PANEL_WIDTH - 1);
    localparam logic [15:0] HM1 = 16'(PANEL_HEIGHT - 1);

    logic [1:0]  r_rotation;
    logic [15:0] w_x1, w_y1, w_x2, w_y2;
    logic [15:0] w_xs, w_xe, w_ys, w_ye, w_cx, w_cy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotation <= ROT_0;
        end else if (i_cfg_valid) begin
            r_rotation <= i_cfg_data;
        end
    end

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full && (i_in.func != FUNC_NONE);

    always_comb begin
        unique case (i_in.func)
            FUNC_PIXEL: begin
                w_x1 = 16'(i_in.x_first);
                w_y1 = 16'(i_in.y_first);
                w_x2 = 16'(i_in.x_first);
                w_y2 = 16'(i_in.y_first);
            end
            FUNC_WINDOW: begin
                w_x1 = 16'(i_in.x_first);
                w_y1 = 16'(i_in.y_first);
                w_x2 = 16'(i_in.x_second);
                w_y2 = 16'(i_in.y_second);
            end
            FUNC_ROTATE: begin
                w_x1 = '0;
                w_y1 = '0;
                w_x2 = r_rotation[0] ? HM1 : WM1;
                w_y2 = r_rotation[0] ? WM1 : HM1;
            end
            default: begin
                w_x1 = '0;
                w_y1 = '0;
                w_x2 = '0;
                w_y2 = '0;
            end
        endcase
    end

    always_comb begin
        unique case (r_rotation)
            ROT_90: begin
                w_xs = WM1 - w_y2;
                w_xe = WM1 - w_y1;
                w_ys = w_x1;
                w_ye = w_x2;
                w_cx = w_xe;
                w_cy = w_ys;
            end
            ROT_180: begin
                w_xs = WM1 - w_x2;
                w_xe = WM1 - w_x1;
                w_ys = HM1 - w_y2;
                w_ye = HM1 - w_y1;
                w_cx = w_xe;
                w_cy = w_ye;
            end
            ROT_270: begin
                w_xs = w_y1;
                w_xe = w_y2;
                w_ys = HM1 - w_x2;
                w_ye = HM1 - w_x1;
                w_cx = w_xs;
                w_cy = w_ye;
            end
            default: begin
                w_xs = w_x1;
                w_xe = w_x2;
                w_ys = w_y1;
                w_ye = w_y2;
                w_cx = w_xs;
                w_cy = w_ys;
            end
        endcase
    end

    always_comb begin
        o_job.words = '0;
        unique case (i_in.func)
            FUNC_PIXEL: begin
                o_job.kind     = KIND_PIXEL;
                o_job.words[0] = w_cx;
                o_job.words[1] = w_cy;
                o_job.words[2] = i_in.pixel_color;
            end
            FUNC_ROTATE: begin
                o_job.kind     = KIND_ROTATE;
                o_job.words[0] = mode_word(r_rotation);
                o_job.words[1] = w_xs;
                o_job.words[2] = w_xe;
                o_job.words[3] = w_ys;
                o_job.words[4] = w_ye;
                o_job.words[5] = w_cx;
                o_job.words[6] = w_cy;
            end
            default: begin
                o_job.kind     = KIND_WINDOW;
                o_job.words[0] = w_xs;
                o_job.words[1] = w_xe;
                o_job.words[2] = w_ys;
                o_job.words[3] = w_ye;
                o_job.words[4] = w_cx;
                o_job.words[5] = w_cy;
            end
        endcase
    end

endmodule

// ----- rtl/core/rpcs_queue.sv -----
// Job queue between the front end and the byte sequencer.
// Depends on rpcs_pkg for the job type.
module rpcs_queue import rpcs_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_valid,
    output logic o_full,
    output t_job o_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_FULL);
    assign o_job   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ----- rtl/core/rpcs_back.sv -----
// Back end: walks the head job byte by byte into the output register.
// Depends on rpcs_pkg for job, output types and address tables.
module rpcs_back import rpcs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_job      i_q_job,
    output logic      o_q_pop,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_item o_out
);

    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;
    logic [REG_W-1:0] w_reg;
    logic [1:0]       w_sub;
    logic [15:0]      w_addr, w_data;
    logic             w_last, w_advance;

    assign w_reg     = r_idx[IDX_W-1:2];
    assign w_sub     = r_idx[1:0];
    assign w_addr    = reg_addr(i_q_job.kind, w_reg);
    assign w_data    = i_q_job.words[w_reg];
    assign w_last    = (w_reg == last_reg(i_q_job.kind)) && (w_sub == 2'd3);
    assign w_advance = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_q_pop   = w_advance && w_last;

    always_comb begin
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_advance) begin
            n_idx       = w_last ? '0 : r_idx + 1'b1;
            n_out_valid = 1'b1;
            unique case (w_sub)
                2'd0:    n_out.bus_byte = w_addr[15:8];
                2'd1:    n_out.bus_byte = w_addr[7:0];
                2'd2:    n_out.bus_byte = w_data[15:8];
                default: n_out.bus_byte = w_data[7:0];
            endcase
            n_out.is_data = w_sub[1];
            n_out.last    = w_last;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ----- rtl/core/rotated_panel_command_serializer.sv -----
// Panel command serializer: front end, job queue, byte sequencer.
// The first byte passes the job queue and the output register; then one byte
// per cycle while jobs wait and i_out_ready holds. Items go out as 12 (pixel),
// 24 (window) or 28 (rotation) bytes; an unused selector is taken and dropped.
// Reset: rotation 0, queue empty, no byte pending. Depends on rpcs_pkg.
module rotated_panel_command_serializer import rpcs_pkg::*; #(
    parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out
);

    logic w_q_push, w_q_pop, w_q_valid, w_q_full;
    t_job w_front_job, w_head_job;

    assign o_cfg_ready = 1'b1;

    rpcs_front #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .i_q_full    (w_q_full),
        .o_in_ready  (o_in_ready),
        .o_push      (w_q_push),
        .o_job       (w_front_job)
    );

    rpcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_job   (w_front_job),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_job   (w_head_job)
    );

    rpcs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_job     (w_head_job),
        .o_q_pop     (w_q_pop),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    a_pop_emits_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |=> o_out_valid && o_out.last)
        else $error("job retired without a final byte");

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push |=> w_q_valid)
        else $error("queue empty after a push");

    a_last_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.last |-> o_out.is_data)
        else $error("final byte tagged as command");

endmodule
